[rtl/alc_pkg.sv]
// Shared constants, command codes and word types for the LRU write-back cache.
package alc_pkg;

  localparam int NUM_LINES  = 32;
  localparam int LINE_WORDS = 8;
  localparam int MEM_WORDS  = 1024;

  localparam int ADDR_W  = 10;
  localparam int DATA_W  = 16;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 32;

  localparam int OFF_W      = $clog2(LINE_WORDS);
  localparam int WORD_W     = (OFF_W > 0) ? OFF_W : 1;
  localparam int TAG_W      = ADDR_W - OFF_W;
  localparam int LINE_IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int WORD_CNT_W = $clog2(LINE_WORDS + 1);
  localparam int LINE_AW    = LINE_IDX_W + WORD_W;
  localparam int LINE_DEPTH = 1 << LINE_AW;
  localparam int MEM_AW     = $clog2(MEM_WORDS);

  localparam logic [CMD_W-1:0] CMD_READ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PRELOAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } alc_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               hit;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } alc_rsp_t;

  typedef struct packed {
    logic                  clear;
    logic                  step;
    logic [LINE_IDX_W-1:0] line;
  } alc_lru_ctrl_t;

endpackage

[rtl/alc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module alc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/alc_lru.sv]
// LRU order as a rotating shift line; one step per cycle with ctrl.step moves a line back.
module alc_lru
  import alc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  alc_lru_ctrl_t         ctrl,
  output logic [LINE_IDX_W-1:0] victim
);

  logic [LINE_IDX_W-1:0] order      [NUM_LINES];
  logic [LINE_IDX_W-1:0] order_next [NUM_LINES];
  logic                  seen;

  // before the line is seen: rotate all; after: rotate all but the tail
  always_comb begin
    for (int i = 0; i < NUM_LINES - 1; i++) begin
      order_next[i] = order[i + 1];
    end
    order_next[NUM_LINES - 1] = seen ? order[NUM_LINES - 1] : order[0];
    if (seen) begin
      order_next[NUM_LINES - 2] = order[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        order[i] <= LINE_IDX_W'(i);
      end
      seen <= 1'b0;
    end else if (ctrl.clear) begin
      seen <= 1'b0;
    end else if (ctrl.step) begin
      seen <= seen | (order[0] == ctrl.line);
      for (int i = 0; i < NUM_LINES; i++) begin
        order[i] <= order_next[i];
      end
    end
  end

  assign victim = order[0];

endmodule

[rtl/assoc_lru_writeback_cache.sv]
// Top level: sequencer, line store, backing store and counters of the LRU write-back cache.
//
//  channel    signals                  transfer
//  request    start, busy, request     start high while busy low
//  response   done, response           done high for one cycle, always taken
//
// After reset a clearing pass writes 0xFFFF to every backing word, with busy high.
// Read/write: tag search (one compare a cycle), then an LRU update pass, access and
// response. A miss adds a victim step, a write-back of a dirty victim and the refill.
// Flush: a scan of all lines, writing back each dirty line. Others: access and response.
// busy stays high until the response cycle ends; the response cannot be stalled.
module assoc_lru_writeback_cache
  import alc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alc_req_t request,
  output logic     done,
  output alc_rsp_t response
);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_SEARCH = 10'b0000000100,
    S_VICT   = 10'b0000001000,
    S_WB     = 10'b0000010000,
    S_FILL   = 10'b0000100000,
    S_LRU    = 10'b0001000000,
    S_ACCESS = 10'b0010000000,
    S_RESP   = 10'b0100000000,
    S_FLUSH  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_LINE,
    SRC_BACK
  } src_t;

  localparam logic [LINE_IDX_W-1:0] LAST_LINE = LINE_IDX_W'(NUM_LINES - 1);
  localparam logic [WORD_CNT_W-1:0] WORD_END  = WORD_CNT_W'(LINE_WORDS);
  localparam logic [MEM_AW-1:0]     CLR_LAST  = MEM_AW'(MEM_WORDS - 1);

  state_t                state, state_next;
  alc_req_t              req;
  logic [LINE_IDX_W-1:0] k;
  logic [LINE_IDX_W-1:0] line;
  logic [WORD_CNT_W-1:0] j;
  logic                  pend;
  logic [WORD_W-1:0]     pend_j;
  logic [TAG_W-1:0]      wb_tag;
  logic                  hit_r;
  logic                  flushing;
  src_t                  src;
  logic [MEM_AW-1:0]     clr;
  logic [COUNT_W-1:0]    hits;
  logic [COUNT_W-1:0]    misses;
  logic                  valid    [NUM_LINES];
  logic                  dirty    [NUM_LINES];
  logic [TAG_W-1:0]      line_tag [NUM_LINES];

  logic [TAG_W-1:0]      req_tag;
  logic [WORD_W-1:0]     req_off;
  logic [WORD_W-1:0]     j_idx;
  logic [MEM_AW-1:0]     wb_maddr;
  logic [MEM_AW-1:0]     fill_maddr;
  logic                  tag_hit;
  logic [LINE_IDX_W-1:0] victim;
  alc_lru_ctrl_t         lru_ctrl;

  logic                  lw_we;
  logic [LINE_AW-1:0]    lw_waddr;
  logic [DATA_W-1:0]     lw_wdata;
  logic [LINE_AW-1:0]    lw_raddr;
  logic [DATA_W-1:0]     lw_rdata;
  logic                  bm_we;
  logic [MEM_AW-1:0]     bm_waddr;
  logic [DATA_W-1:0]     bm_wdata;
  logic [MEM_AW-1:0]     bm_raddr;
  logic [DATA_W-1:0]     bm_rdata;

  assign req_tag    = TAG_W'(req.address / LINE_WORDS);
  assign req_off    = WORD_W'(req.address % LINE_WORDS);
  assign j_idx      = WORD_W'(j);
  assign wb_maddr   = MEM_AW'((ADDR_W'(wb_tag) << OFF_W) + ADDR_W'(pend_j));
  assign fill_maddr = MEM_AW'((ADDR_W'(req_tag) << OFF_W) + ADDR_W'(j_idx));
  assign tag_hit    = valid[k] && (line_tag[k] == req_tag);

  alc_ram #(.WIDTH(DATA_W), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (lw_we),
    .waddr (lw_waddr),
    .wdata (lw_wdata),
    .raddr (lw_raddr),
    .rdata (lw_rdata)
  );

  alc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_back_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  alc_lru u_lru (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lru_ctrl),
    .victim (victim)
  );

  always_comb begin
    state_next     = state;
    lw_we          = 1'b0;
    lw_waddr       = {line, req_off};
    lw_wdata       = req.write_data;
    lw_raddr       = {line, j_idx};
    bm_we          = 1'b0;
    bm_waddr       = wb_maddr;
    bm_wdata       = lw_rdata;
    bm_raddr       = fill_maddr;
    lru_ctrl.clear = 1'b0;
    lru_ctrl.step  = 1'b0;
    lru_ctrl.line  = line;
    unique case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr;
        bm_wdata = '1;
        if (clr == CLR_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (request.command inside {CMD_READ, CMD_WRITE}) begin
            state_next = S_SEARCH;
          end else if (request.command == CMD_FLUSH) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_ACCESS;
          end
        end
      end
      S_SEARCH: begin
        if (tag_hit) begin
          lru_ctrl.clear = 1'b1;
          state_next     = S_LRU;
        end else if (k == LAST_LINE) begin
          state_next = S_VICT;
        end
      end
      S_VICT: begin
        state_next = dirty[line] ? S_WB : S_FILL;
      end
      S_WB: begin
        bm_we = pend;
        if (j == WORD_END) begin
          state_next = flushing ? S_FLUSH : S_FILL;
        end
      end
      S_FILL: begin
        lw_we    = pend;
        lw_waddr = {line, pend_j};
        lw_wdata = bm_rdata;
        if (j == WORD_END) begin
          lru_ctrl.clear = 1'b1;
          state_next     = S_LRU;
        end
      end
      S_LRU: begin
        lru_ctrl.step = 1'b1;
        if (k == LAST_LINE) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        lw_raddr = {line, req_off};
        bm_raddr = MEM_AW'(req.address);
        if (req.command == CMD_WRITE) begin
          lw_we = 1'b1;
        end
        if (req.command == CMD_PRELOAD) begin
          bm_we    = 1'b1;
          bm_waddr = MEM_AW'(req.address);
          bm_wdata = req.write_data;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      S_FLUSH: begin
        if (dirty[k]) begin
          state_next = S_WB;
        end else if (k == LAST_LINE) begin
          state_next = S_RESP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      clr    <= '0;
      hits   <= '0;
      misses <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        valid[i] <= 1'b0;
        dirty[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            req      <= request;
            k        <= '0;
            hit_r    <= 1'b0;
            flushing <= (request.command == CMD_FLUSH);
            src      <= SRC_ZERO;
          end
        end
        S_SEARCH: begin
          if (tag_hit) begin
            line  <= k;
            hit_r <= 1'b1;
            k     <= '0;
            if (hits != '1) begin
              hits <= hits + 1'b1;
            end
          end else if (k == LAST_LINE) begin
            line <= victim;
            k    <= victim;
            if (misses != '1) begin
              misses <= misses + 1'b1;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_VICT: begin
          wb_tag <= line_tag[k];
          j      <= '0;
          pend   <= 1'b0;
        end
        S_WB, S_FILL: begin
          if (j == WORD_END) begin
            pend <= 1'b0;
            j    <= '0;
            if (state == S_WB) begin
              dirty[line] <= 1'b0;
            end else begin
              valid[line]    <= 1'b1;
              line_tag[line] <= req_tag;
              k              <= '0;
            end
          end else begin
            j      <= j + 1'b1;
            pend   <= 1'b1;
            pend_j <= j_idx;
          end
        end
        S_LRU: begin
          k <= k + 1'b1;
        end
        S_ACCESS: begin
          if (req.command == CMD_WRITE) begin
            dirty[line] <= 1'b1;
          end
          if (req.command == CMD_READ) begin
            src <= SRC_LINE;
          end else if (req.command == CMD_PEEK) begin
            src <= SRC_BACK;
          end else begin
            src <= SRC_ZERO;
          end
        end
        S_RESP: begin
        end
        S_FLUSH: begin
          if (dirty[k]) begin
            line   <= k;
            wb_tag <= line_tag[k];
            j      <= '0;
            pend   <= 1'b0;
          end else if (k != LAST_LINE) begin
            k <= k + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  always_comb begin
    case (src)
      SRC_LINE: response.read_data = lw_rdata;
      SRC_BACK: response.read_data = bm_rdata;
      default:  response.read_data = '0;
    endcase
    response.hit        = hit_r;
    response.hit_count  = hits;
    response.miss_count = misses;
  end

endmodule

[rtl/alc_checker.sv]
// Port-level checks on the cache handshake and counters, bound to the top level.
module alc_checker
  import alc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input alc_req_t request,
  input logic     done,
  input alc_rsp_t response
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("response strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("response strobe longer than one cycle");

  a_hits_mono: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (response.hit_count >= $past(response.hit_count)))
    else $error("hit count decreased");

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (done && response.hit) |-> (response.hit_count != '0))
    else $error("hit reported with zero hit count");

endmodule

bind assoc_lru_writeback_cache alc_checker u_alc_checker (.*);

[bench/tb_assoc_lru_writeback_cache.sv]
// Self-checking bench for the LRU write-back cache: directed table, random traffic, predictor.
module tb_assoc_lru_writeback_cache
  import alc_pkg::*;
();

  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  alc_req_t request = '0;
  alc_rsp_t response;

  assoc_lru_writeback_cache dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .response(response)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [TAG_W-1:0]   cache_tag [NUM_LINES];
  logic               cache_valid [NUM_LINES];
  logic               cache_dirty [NUM_LINES];
  logic [DATA_W-1:0]  cache_word [NUM_LINES][LINE_WORDS];
  int                 lru_order [NUM_LINES];
  logic [DATA_W-1:0]  backing [MEM_WORDS];
  logic [COUNT_W-1:0] hits_seen;
  logic [COUNT_W-1:0] misses_seen;

  alc_rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;

  typedef struct {
    alc_req_t req;
    logic     fixed;
    alc_rsp_t rsp;
  } stim_row_t;

  function automatic alc_rsp_t mk_rsp(logic [DATA_W-1:0] d, logic h,
                                      logic [COUNT_W-1:0] hc, logic [COUNT_W-1:0] mc);
    alc_rsp_t r;
    r.read_data = d; r.hit = h; r.hit_count = hc; r.miss_count = mc;
    return r;
  endfunction

  function automatic alc_req_t mk_req(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] a,
                                      logic [DATA_W-1:0] d);
    alc_req_t r;
    r.command = c; r.address = a; r.write_data = d;
    return r;
  endfunction

  function automatic void touch_line(int line);
    int pos;
    pos = 0;
    for (int i = 0; i < NUM_LINES; i++)
      if (lru_order[i] == line) pos = i;
    for (int i = pos; i < NUM_LINES - 1; i++) lru_order[i] = lru_order[i + 1];
    lru_order[NUM_LINES - 1] = line;
  endfunction

  function automatic void spill_line(int line);
    for (int i = 0; i < LINE_WORDS; i++)
      backing[(cache_tag[line] * LINE_WORDS + i) % MEM_WORDS] = cache_word[line][i];
  endfunction

  function automatic alc_rsp_t cache_model(alc_req_t req);
    logic [DATA_W-1:0] rd;
    logic h;
    logic [TAG_W-1:0] tg;
    int off, line;
    rd = '0; h = 1'b0;
    tg = TAG_W'(req.address / LINE_WORDS);
    off = req.address % LINE_WORDS;
    line = -1;
    case (req.command)
      CMD_READ, CMD_WRITE: begin
        for (int i = 0; i < NUM_LINES; i++)
          if (line < 0 && cache_valid[i] && cache_tag[i] == tg) line = i;
        if (line >= 0) begin
          touch_line(line);
          h = 1'b1;
          if (hits_seen != '1) hits_seen++;
        end else begin
          line = lru_order[0];
          touch_line(line);
          if (cache_dirty[line]) begin
            spill_line(line);
            cache_dirty[line] = 1'b0;
          end
          for (int i = 0; i < LINE_WORDS; i++)
            cache_word[line][i] = backing[(tg * LINE_WORDS + i) % MEM_WORDS];
          cache_valid[line] = 1'b1;
          cache_tag[line] = tg;
          if (misses_seen != '1) misses_seen++;
        end
        if (req.command == CMD_READ) rd = cache_word[line][off];
        else begin
          cache_word[line][off] = req.write_data;
          cache_dirty[line] = 1'b1;
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NUM_LINES; i++)
          if (cache_dirty[i]) begin
            spill_line(i);
            cache_dirty[i] = 1'b0;
          end
      end
      CMD_PRELOAD: backing[req.address % MEM_WORDS] = req.write_data;
      CMD_PEEK: rd = backing[req.address % MEM_WORDS];
      default: ;
    endcase
    return mk_rsp(rd, h, hits_seen, misses_seen);
  endfunction

  // response checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected word %h", $time, response);
        errors++;
      end else begin
        alc_rsp_t e;
        e = pending_rsp.pop_front();
        if (response.read_data !== e.read_data) begin
          $display("%0t: read_data exp %h got %h", $time, e.read_data, response.read_data);
          errors++;
        end
        if (response.hit !== e.hit) begin
          $display("%0t: hit exp %b got %b", $time, e.hit, response.hit);
          errors++;
        end
        if (response.hit_count !== e.hit_count) begin
          $display("%0t: hit_count exp %0d got %0d", $time, e.hit_count, response.hit_count);
          errors++;
        end
        if (response.miss_count !== e.miss_count) begin
          $display("%0t: miss_count exp %0d got %0d", $time, e.miss_count,
                   response.miss_count);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  logic quiet;

  // start drops at the accepting edge; the block stays busy past the next edge
  task automatic send_word(alc_req_t req, logic fixed, alc_rsp_t fixed_rsp);
    alc_rsp_t p;
    @(posedge clk);
    if (!quiet)
      while ($urandom_range(99) < 18) @(posedge clk);
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    p = cache_model(req);
    if (fixed && p !== fixed_rsp) begin
      $display("%0t: table row exp %h predictor %h", $time, fixed_rsp, p);
      errors++;
    end
    pending_rsp.insert(pending_rsp.size(), p);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic alc_req_t rand_req(int hot_tags);
    alc_req_t r;
    int k;
    k = $urandom_range(99);
    r.write_data = DATA_W'($urandom());
    if (k < 3) r.command = CMD_W'($urandom_range(7, 5));
    else if (k < 6) r.command = CMD_FLUSH;
    else if (k < 14) r.command = CMD_PRELOAD;
    else if (k < 22) r.command = CMD_PEEK;
    else if (k < 61) r.command = CMD_READ;
    else r.command = CMD_WRITE;
    if (hot_tags > 0)
      r.address = ADDR_W'(($urandom_range(hot_tags - 1) * LINE_WORDS
                           + $urandom_range(LINE_WORDS - 1)) % (1 << ADDR_W));
    else r.address = ADDR_W'($urandom());
    return r;
  endfunction

  stim_row_t rows [$];

  task automatic add_row(alc_req_t req, logic fixed, alc_rsp_t rsp);
    stim_row_t r;
    r.req = req;
    r.fixed = fixed;
    r.rsp = rsp;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    for (int i = 0; i < NUM_LINES; i++) begin
      cache_valid[i] = 1'b0; cache_dirty[i] = 1'b0; lru_order[i] = i; cache_tag[i] = '0;
      for (int j = 0; j < LINE_WORDS; j++) cache_word[i][j] = '0;
    end
    for (int i = 0; i < MEM_WORDS; i++) backing[i] = 16'hFFFF;
    hits_seen = '0; misses_seen = '0;
    quiet = 1'b0;

    add_row(mk_req(CMD_PEEK, 10'd0, 16'h0), 1'b1, mk_rsp(16'hFFFF, 1'b0, 32'd0, 32'd0));
    add_row(mk_req(CMD_PEEK, 10'h3FF, 16'h0), 1'b1, mk_rsp(16'hFFFF, 1'b0, 32'd0, 32'd0));
    add_row(mk_req(3'd5, 10'h3FF, 16'hFFFF), 1'b1, mk_rsp(16'h0, 1'b0, 32'd0, 32'd0));
    add_row(mk_req(3'd7, 10'h155, 16'hAAAA), 1'b1, mk_rsp(16'h0, 1'b0, 32'd0, 32'd0));
    add_row(mk_req(CMD_READ, 10'd0, 16'h0), 1'b1, mk_rsp(16'hFFFF, 1'b0, 32'd0, 32'd1));
    add_row(mk_req(CMD_READ, 10'd7, 16'h0), 1'b1, mk_rsp(16'hFFFF, 1'b1, 32'd1, 32'd1));
    add_row(mk_req(CMD_PRELOAD, 10'h3FF, 16'h0000), 1'b1,
            mk_rsp(16'h0, 1'b0, 32'd1, 32'd1));
    add_row(mk_req(CMD_PEEK, 10'h3FF, 16'h0), 1'b1, mk_rsp(16'h0000, 1'b0, 32'd1, 32'd1));
    add_row(mk_req(CMD_WRITE, 10'h3FF, 16'hFFFF), 1'b0, '0);
    add_row(mk_req(CMD_READ, 10'h3FF, 16'h0), 1'b0, '0);
    add_row(mk_req(CMD_PRELOAD, 10'h3F8, 16'h1234), 1'b0, '0);
    add_row(mk_req(CMD_READ, 10'h3F8, 16'h0), 1'b0, '0);
    add_row(mk_req(CMD_PEEK, 10'h3FF, 16'h0), 1'b0, '0);
    add_row(mk_req(CMD_FLUSH, 10'h0, 16'h0), 1'b0, '0);
    add_row(mk_req(CMD_PEEK, 10'h3FF, 16'h0), 1'b0, '0);
    add_row(mk_req(CMD_WRITE, 10'h2AA, 16'h5555), 1'b0, '0);
    add_row(mk_req(CMD_FLUSH, 10'h3FF, 16'hFFFF), 1'b0, '0);
    add_row(mk_req(CMD_FLUSH, 10'h0, 16'h0), 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].req, rows[i].fixed, rows[i].rsp);
    // write NUM_LINES + 4 distinct lines dirty, more than the cache holds, so dirty lines get evicted
    for (int i = 0; i < NUM_LINES + 4; i++)
      send_word(mk_req(CMD_WRITE, ADDR_W'(i * LINE_WORDS + 3), DATA_W'($urandom())),
                1'b0, '0);
    drain();

    for (int n = 0; n < 500; n++) begin
      quiet = (n >= 200 && n < 280);
      send_word(rand_req(n < 350 ? 40 : 0), 1'b0, '0);
      if (n == 300) drain();
    end
    drain();
    repeat (NUM_LINES * 3 + 20) @(posedge clk);

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/alc_pkg.sv
rtl/alc_ram.sv
rtl/alc_lru.sv
rtl/assoc_lru_writeback_cache.sv
rtl/alc_checker.sv
bench/tb_assoc_lru_writeback_cache.sv
